[rtl/spd_pkg.sv]
// Shared types and constants for the serial packet deframer with XOR check.
// No dependencies; used by every module of the block by scoped names.
package spd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned StatusW = 2;

  localparam logic [ByteW-1:0] StartByteReset = 8'hAA;
  localparam logic [ByteW-1:0] XorInit = 8'h00;
  localparam logic [ByteW-1:0] MinLength = 8'd3;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_SUM = 2'd1,
    STATUS_BAD_LEN = 2'd2
  } status_t;

  // One result beat
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [ByteW-1:0] position;
    logic             last;
    status_t          status;
  } result_t;

endpackage

[rtl/spd_in_stage.sv]
// Input register stage: holds one received byte until the framer takes it.
// Depends on spd_pkg for the byte width.
module spd_in_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [spd_pkg::ByteW-1:0] in_data_byte,
  output logic                     item_valid,
  output logic [spd_pkg::ByteW-1:0] item_byte,
  input  logic                     item_take
);

  logic                      valid_r, valid_nxt;
  logic [spd_pkg::ByteW-1:0] data_r, data_nxt;
  logic                      accept;

  // free when empty or when the held byte leaves this cycle
  assign in_ready = !valid_r || item_take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (accept) begin
      valid_nxt = 1'b1;
      data_nxt  = in_data_byte;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign item_valid = valid_r;
  assign item_byte  = data_r;

endmodule

[rtl/spd_frame_ctl.sv]
// Framing state (count, length, running XOR) and the per-byte decision logic.
// Depends on spd_pkg for widths, status codes and the result struct.
module spd_frame_ctl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  input  logic [spd_pkg::ByteW-1:0] item_byte,
  input  logic [spd_pkg::ByteW-1:0] start_byte,
  input  logic                      out_free,
  output logic                      item_take,
  output logic                      res_valid,
  output spd_pkg::result_t          res
);

  logic [spd_pkg::ByteW-1:0] count_r, count_nxt;
  logic [spd_pkg::ByteW-1:0] len_r, len_nxt;
  logic [spd_pkg::ByteW-1:0] xor_r, xor_nxt;
  logic                      hunting;
  logic                      produce;
  logic                      at_end;
  logic [spd_pkg::ByteW:0]   count_p1;

  assign hunting  = (count_r == '0);
  assign produce  = !hunting || (item_byte == start_byte);
  // a dropped byte needs no output slot
  assign item_take = item_valid && (out_free || !produce);
  assign res_valid = item_take && produce;
  assign count_p1  = {1'b0, count_r} + {{spd_pkg::ByteW{1'b0}}, 1'b1};
  assign at_end    = (count_p1 >= {1'b0, len_r});

  // result fields and next state
  always_comb begin
    count_nxt    = count_r;
    len_nxt      = len_r;
    xor_nxt      = xor_r;
    res.out_byte = item_byte;
    res.position = count_r;
    res.last     = 1'b0;
    res.status   = spd_pkg::STATUS_OK;
    if (hunting) begin
      if (produce) begin
        xor_nxt   = spd_pkg::XorInit ^ item_byte;
        count_nxt = 8'd1;
      end
    end else if (count_r == 8'd1) begin
      if (item_byte < spd_pkg::MinLength) begin
        res.last   = 1'b1;
        res.status = spd_pkg::STATUS_BAD_LEN;
        count_nxt  = '0;
        len_nxt    = '0;
        xor_nxt    = spd_pkg::XorInit;
      end else begin
        len_nxt   = item_byte;
        xor_nxt   = xor_r ^ item_byte;
        count_nxt = 8'd2;
      end
    end else if (at_end) begin
      // checksum byte
      res.last   = 1'b1;
      res.status = (item_byte == xor_r) ? spd_pkg::STATUS_OK : spd_pkg::STATUS_BAD_SUM;
      count_nxt  = '0;
      len_nxt    = '0;
      xor_nxt    = spd_pkg::XorInit;
    end else begin
      xor_nxt   = xor_r ^ item_byte;
      count_nxt = count_p1[spd_pkg::ByteW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      len_r   <= '0;
      xor_r   <= spd_pkg::XorInit;
    end else if (item_take) begin
      count_r <= count_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
    end
  end

endmodule

[rtl/serial_packet_deframer_xor_check_core.sv]
// Serial packet deframer with XOR check, top level.
// An accepted byte passes the input register, then the result register, to reach out_*.
// Throughput: one byte per cycle while the output is not stalled; input register and
// result register decouple the two channels, so the input register can take one new beat while a result waits.
// Reset (rst_n low, synchronous): hunting for start, start byte 0xAA, no beats held.
// Depends on spd_pkg, spd_in_stage and spd_frame_ctl.
module serial_packet_deframer_xor_check_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [spd_pkg::ByteW-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [spd_pkg::ByteW-1:0] in_data_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [spd_pkg::ByteW-1:0] out_out_byte,
  output logic [spd_pkg::ByteW-1:0] out_position,
  output logic                      out_last,
  output logic [spd_pkg::StatusW-1:0] out_status
);

  logic [spd_pkg::ByteW-1:0] start_byte_r;
  logic                      item_valid;
  logic [spd_pkg::ByteW-1:0] item_byte;
  logic                      item_take;
  logic                      res_valid;
  spd_pkg::result_t          res;
  logic                      out_valid_r, out_valid_nxt;
  spd_pkg::result_t          out_r;
  logic                      out_free;

  // start byte register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= spd_pkg::StartByteReset;
    end else if (cfg_wr_en) begin
      start_byte_r <= cfg_wr_data;
    end
  end

  spd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .item_valid   (item_valid),
    .item_byte    (item_byte),
    .item_take    (item_take)
  );

  spd_frame_ctl u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .start_byte (start_byte_r),
    .out_free   (out_free),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_out_byte = out_r.out_byte;
  assign out_position = out_r.position;
  assign out_last     = out_r.last;
  assign out_status   = out_r.status;

endmodule
